// ----- rtl/json_token_syntax_checker_core_defines.svh -----
// Assertion helpers shared by the checker RTL.
// Both expect signals named clk and rst in the scope of use.
`ifndef JSON_TOKEN_SYNTAX_CHECKER_CORE_DEFINES_SVH
`define JSON_TOKEN_SYNTAX_CHECKER_CORE_DEFINES_SVH

// Condition must hold at every edge outside reset.
`define JTSC_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define JTSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/jtsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package jtsc_pkg;

  // Default stack depth
  localparam int MAX_NEST_DEF = 32;

  // Depth limit register
  localparam int          LIMIT_W     = 6;
  localparam logic [5:0]  LIMIT_RESET = 6'd32;

  // Token kinds
  localparam logic [3:0] K_STRING = 4'd0;
  localparam logic [3:0] K_NUMBER = 4'd1;
  localparam logic [3:0] K_LCURL  = 4'd2;
  localparam logic [3:0] K_RCURL  = 4'd3;
  localparam logic [3:0] K_LBRACK = 4'd4;
  localparam logic [3:0] K_RBRACK = 4'd5;
  localparam logic [3:0] K_COMMA  = 4'd6;
  localparam logic [3:0] K_COLON  = 4'd7;

  typedef enum logic [3:0] {
    PH_FIRST    = 4'd0,
    PH_VALUE    = 4'd1,
    PH_OBJ_OPEN = 4'd2,
    PH_KEY      = 4'd3,
    PH_COLON    = 4'd4,
    PH_ARR_OPEN = 4'd5,
    PH_AFTER    = 4'd6,
    PH_DONE     = 4'd7,
    PH_ERROR    = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_ERROR    = 3'd2,
    ST_DEEP     = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/jtsc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write port, one registered read port.
module jtsc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = jtsc_pkg::MAX_NEST_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/json_token_syntax_checker_core.sv -----
// Each accepted token's result is registered into the output stage, or the skid slot if held.
// Throughput: one token per cycle while in_stall is low; the phase update, the top-of-stack
//   register and the registered RAM read of the entry below the top close at the same edge.
// Reset (rst, synchronous, active high): phase to expect-first-value, depth 0, limit 32,
//   output and skid stages empty. The stack RAM is not cleared; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module json_token_syntax_checker_core #(
  parameter int MAX_NEST = jtsc_pkg::MAX_NEST_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // token input
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [3:0] token_kind,
  input  wire logic       restart,
  // result output
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [2:0] status,
  output logic      [5:0] depth,
  // depth limit register write
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [5:0] cfg_data
);

`include "json_token_syntax_checker_core_defines.svh"

  localparam int LW = $clog2(MAX_NEST + 1);          // depth counter, holds MAX_NEST itself
  localparam int AW = $clog2(MAX_NEST);              // stack address
  localparam int CW = (LW > jtsc_pkg::LIMIT_W) ? LW : jtsc_pkg::LIMIT_W;

  // ---------------------------------------------------------------------------
  // Config: limit register. Always ready; user must keep it written only while idle; unchecked.
  // ---------------------------------------------------------------------------
  logic [5:0] limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= jtsc_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. Output register plus a skid slot: the core keeps accepting
  // while one item waits; it stalls only once the skid slot is occupied.
  // ---------------------------------------------------------------------------
  logic acc;
  logic take;
  logic skid_v;

  assign in_stall = skid_v;
  assign acc      = in_valid && !skid_v;
  assign take     = out_valid && !out_stall;

  // ---------------------------------------------------------------------------
  // Parser state.
  //   level       : current nesting depth
  //   top_is_obj  : kind of innermost open container (valid when level >= 1)
  //   below_is_obj: RAM read of entry level-2 (valid when level >= 2)
  // The RAM read address is registered from the next level, so the entry
  // below the top is always waiting when the next token arrives.
  // ---------------------------------------------------------------------------
  jtsc_pkg::phase_t phase, ph_next, ph_eff;
  logic [LW-1:0]    level, lvl_next, lvl_eff;
  logic             top_is_obj, top_next;
  logic             below_is_obj;

  jtsc_pkg::status_t st;
  logic              push;
  logic              push_obj;
  logic              do_start, do_close, close_obj, do_fail;
  logic              too_deep;
  logic              rd_src_acc;
  logic [LW-1:0]     rd_level;
  logic [AW-1:0]     rd_addr;

  // Limit in force: min(register, MAX_NEST). Opening at level >= limit is too deep.
  assign too_deep = (CW'(lvl_eff) >= CW'(limit)) || (lvl_eff == LW'(MAX_NEST));
  assign push_obj = (token_kind == jtsc_pkg::K_LCURL);

  always_comb begin
    lvl_eff   = restart ? '0 : level;
    ph_eff    = restart ? jtsc_pkg::PH_FIRST : phase;
    ph_next   = ph_eff;
    lvl_next  = lvl_eff;
    top_next  = top_is_obj;
    push      = 1'b0;
    st        = jtsc_pkg::ST_OK;
    do_start  = 1'b0;
    do_close  = 1'b0;
    close_obj = 1'b0;
    do_fail   = 1'b0;

    case (ph_eff)
      jtsc_pkg::PH_FIRST, jtsc_pkg::PH_VALUE: begin
        do_start = 1'b1;
      end
      jtsc_pkg::PH_OBJ_OPEN: begin
        if (token_kind == jtsc_pkg::K_STRING) begin
          ph_next = jtsc_pkg::PH_COLON;
        end else if (token_kind == jtsc_pkg::K_RCURL) begin
          do_close  = 1'b1;
          close_obj = 1'b1;
        end else begin
          do_fail = 1'b1;
        end
      end
      jtsc_pkg::PH_KEY: begin
        if (token_kind == jtsc_pkg::K_STRING) begin
          ph_next = jtsc_pkg::PH_COLON;
        end else begin
          do_fail = 1'b1;
        end
      end
      jtsc_pkg::PH_COLON: begin
        if (token_kind == jtsc_pkg::K_COLON) begin
          ph_next = jtsc_pkg::PH_VALUE;
        end else begin
          do_fail = 1'b1;
        end
      end
      jtsc_pkg::PH_ARR_OPEN: begin
        if (token_kind == jtsc_pkg::K_RBRACK) begin
          do_close = 1'b1;
        end else begin
          do_start = 1'b1;
        end
      end
      jtsc_pkg::PH_AFTER: begin
        if (token_kind == jtsc_pkg::K_COMMA) begin
          if (lvl_eff == '0) begin
            do_fail = 1'b1;
          end else begin
            ph_next = top_is_obj ? jtsc_pkg::PH_KEY : jtsc_pkg::PH_VALUE;
          end
        end else if (token_kind == jtsc_pkg::K_RCURL) begin
          do_close  = 1'b1;
          close_obj = 1'b1;
        end else if (token_kind == jtsc_pkg::K_RBRACK) begin
          do_close = 1'b1;
        end else begin
          do_fail = 1'b1;
        end
      end
      jtsc_pkg::PH_DONE: begin
        st = jtsc_pkg::ST_IGNORED;
      end
      default: begin
        do_fail = 1'b1;   // error phase sticks
      end
    endcase

    // value may start here
    if (do_start) begin
      if (token_kind == jtsc_pkg::K_STRING || token_kind == jtsc_pkg::K_NUMBER) begin
        if (lvl_eff == '0) begin
          ph_next = jtsc_pkg::PH_DONE;
          st      = jtsc_pkg::ST_COMPLETE;
        end else begin
          ph_next = jtsc_pkg::PH_AFTER;
        end
      end else if (token_kind == jtsc_pkg::K_LCURL || token_kind == jtsc_pkg::K_LBRACK) begin
        if (too_deep) begin
          ph_next = jtsc_pkg::PH_ERROR;
          st      = jtsc_pkg::ST_DEEP;
        end else begin
          push     = 1'b1;
          top_next = push_obj;
          lvl_next = lvl_eff + LW'(1);
          ph_next  = push_obj ? jtsc_pkg::PH_OBJ_OPEN : jtsc_pkg::PH_ARR_OPEN;
        end
      end else begin
        do_fail = 1'b1;
      end
    end

    // closer must match innermost container
    if (do_close) begin
      if (lvl_eff == '0 || top_is_obj != close_obj) begin
        do_fail = 1'b1;
      end else begin
        lvl_next = lvl_eff - LW'(1);
        top_next = below_is_obj;
        if (lvl_next == '0) begin
          ph_next = jtsc_pkg::PH_DONE;
          st      = jtsc_pkg::ST_COMPLETE;
        end else begin
          ph_next = jtsc_pkg::PH_AFTER;
        end
      end
    end

    if (do_fail) begin
      ph_next = jtsc_pkg::PH_ERROR;
      st      = jtsc_pkg::ST_ERROR;
    end
  end

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jtsc_pkg::PH_FIRST;
    end else if (acc) begin
      phase <= ph_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (acc) begin
      level <= lvl_next;
    end
  end

  // top kind is payload; only meaningful while level >= 1
  always_ff @(posedge clk) begin
    if (acc) begin
      top_is_obj <= top_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stack RAM. Push writes entry lvl_eff; the read fetches entry level-2 of
  // the coming state. A push never reads the entry it writes in the same
  // cycle, and anything read was written at an earlier edge.
  // ---------------------------------------------------------------------------
  assign rd_src_acc = acc;
  assign rd_level   = rd_src_acc ? lvl_next : level;
  assign rd_addr    = AW'(rd_level - LW'(2));

  jtsc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_NEST)
  ) u_stack (
    .clk   (clk),
    .we    (acc && push),
    .waddr (AW'(lvl_eff)),
    .wdata (push_obj),
    .raddr (rd_addr),
    .rdata (below_is_obj)
  );

  // ---------------------------------------------------------------------------
  // Output register and skid slot
  // ---------------------------------------------------------------------------
  logic [2:0] skid_status;
  logic [5:0] skid_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (take) begin
        skid_v <= 1'b0;       // skid moves up, out stays valid
      end
    end else if (acc) begin
      if (out_valid && !take) begin
        skid_v <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (take) begin
        status <= skid_status;
        depth  <= skid_depth;
      end
    end else if (acc) begin
      if (out_valid && !take) begin
        skid_status <= st;
        skid_depth  <= 6'(lvl_next);
      end else begin
        status <= st;
        depth  <= 6'(lvl_next);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `JTSC_ASSERT_NOW(a_skid_needs_out, !skid_v || out_valid, "skid holds item with output empty")
  `JTSC_ASSERT_NOW(a_level_bound, level <= LW'(MAX_NEST), "nesting level beyond stack depth")
  `JTSC_ASSERT_NOW(a_done_at_top, phase != jtsc_pkg::PH_DONE || level == '0,
                   "document complete with open containers")
  `JTSC_ASSERT_NEXT(a_error_sticks,
                    acc && !restart && phase == jtsc_pkg::PH_ERROR,
                    phase == jtsc_pkg::PH_ERROR && level == $past(level),
                    "error phase left without restart")

endmodule

`default_nettype wire
